[src/sprite_frame_animation_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer: assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_ANIMATION_SEQUENCER_CORE_DEFINES_SVH
`define SPRITE_FRAME_ANIMATION_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFAS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfas assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> (cons)) \
		else $error("sfas assertion failed");

`endif

[src/sfas_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer package
// Shared widths, register and command codes, and word types.
// ----------------------------------------------------------------------------
package sfas_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int POS_BITS   = FRAC_BITS + 12;
	localparam int FRAME_BITS = POS_BITS - FRAC_BITS;
	localparam int CALC_BITS  = FRAME_BITS + 1;
	localparam int PROD_BITS  = 24;
	localparam int SHL        = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SHR        = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 9;

	localparam logic [CFG_IDX_BITS-1:0] REG_FPS    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COUNT  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT = 3'd4;

	localparam logic [1:0] MODE_NORMAL    = 2'd0;
	localparam logic [1:0] MODE_REVERSED  = 2'd1;
	localparam logic [1:0] MODE_PING_PONG = 2'd2;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_PLAY = 1'b1;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic signed [CALC_BITS-1:0] frame_t;

	typedef struct packed {
		logic [7:0] frames_per_second;
		logic [7:0] start_frame;
		logic [8:0] frame_count;
		logic [1:0] anim_mode;
		logic [7:0] repeat_limit;
	} cfg_t;

	typedef struct packed {
		logic [8:0] frame_index;
		logic       active;
		logic       reached_end;
		logic       moving_backward;
	} result_t;

	// Handshake between the input register and the step stage.
	typedef struct packed {
		logic valid;
		logic take;
	} stage_ctl_t;

endpackage

[src/sfas_ifs.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface sfas_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] delta_time;

	modport source (output valid, func, delta_time, input ready);
	modport sink (input valid, func, delta_time, output ready);
endinterface

interface sfas_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] frame_index;
	logic       active;
	logic       reached_end;
	logic       moving_backward;

	modport source (output valid, frame_index, active, reached_end, moving_backward,
		input ready);
	modport sink (input valid, frame_index, active, reached_end, moving_backward,
		output ready);
endinterface

[src/sprite_frame_animation_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer core
// Advances a fixed-point sprite frame position once per tick word, with
// normal, reversed and ping-pong modes and a repeat limit.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          handshake
//  items     in   func, delta_time                                 valid/ready
//  results   out  frame_index, active, reached_end, moving_backward valid/ready
//  cfg       in   cfg_index, cfg_data                              cfg_we
//
// One word is accepted per cycle while ready is high; its result passes
// through the input register, then the step stage into the result register.
// The increment multiply sits in the input register stage and the position
// update in the step stage, so each stage is one operation deep.
// Reset clears the animation state to frame zero, forward and active.
// A stalled result holds the step stage; an empty input register still
// takes one more word, and ready stays low while it holds a word.
module sprite_frame_animation_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sfas_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sfas_in_if.sink                             items,
	sfas_out_if.source                          results
);
	import sfas_pkg::*;

	cfg_t       cfg;
	stage_ctl_t ctl;
	logic       valid_s1;
	logic       func_s1;
	pos_t       inc_s1;

	sfas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfas_in_reg u_in (
		.clk               (clk),
		.arst_n            (arst_n),
		.frames_per_second (cfg.frames_per_second),
		.items             (items),
		.take              (ctl.take),
		.valid_s1          (valid_s1),
		.func_s1           (func_s1),
		.inc_s1            (inc_s1)
	);

	sfas_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.func_s1  (func_s1),
		.inc_s1   (inc_s1),
		.ctl      (ctl),
		.results  (results)
	);

endmodule

[src/sfas_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer configuration registers
// Write-only register file decoded from the register index.
// ----------------------------------------------------------------------------
module sfas_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sfas_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output sfas_pkg::cfg_t                      cfg
);
	import sfas_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frames_per_second <= '0;
			cfg_q.start_frame       <= '0;
			cfg_q.frame_count       <= 9'd1;
			cfg_q.anim_mode         <= MODE_NORMAL;
			cfg_q.repeat_limit      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FPS:    cfg_q.frames_per_second <= cfg_data[7:0];
				REG_START:  cfg_q.start_frame       <= cfg_data[7:0];
				REG_COUNT:  cfg_q.frame_count       <= cfg_data[8:0];
				REG_MODE:   cfg_q.anim_mode         <= cfg_data[1:0];
				REG_REPEAT: cfg_q.repeat_limit      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/sfas_in_reg.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer input register
// Captures an accepted word and forms the frame-position increment.
// ----------------------------------------------------------------------------
module sfas_in_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                frames_per_second,
	sfas_in_if.sink                   items,
	input  logic                      take,
	output logic                      valid_s1,
	output logic                      func_s1,
	output sfas_pkg::pos_t            inc_s1
);
	import sfas_pkg::*;

	logic                 v_s1;
	logic [PROD_BITS-1:0] prod;
	pos_t                 inc;

	assign items.ready = !v_s1 || take;

	// The user is to hold the rate still while words are in flight (this
	// block does not enforce it), so the product can be formed on entry.
	always_comb begin
		prod = PROD_BITS'(frames_per_second) * PROD_BITS'(items.delta_time);
		if (FRAC_BITS >= 16) begin
			inc = POS_BITS'(prod) << SHL;
		end else begin
			inc = POS_BITS'(prod >> SHR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (items.ready) begin
			v_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			func_s1 <= items.func;
			inc_s1  <= inc;
		end
	end

	assign valid_s1 = v_s1;

endmodule

[src/sfas_step.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer step stage
// Holds the animation state, applies one word and registers the result.
// ----------------------------------------------------------------------------
module sfas_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfas_pkg::cfg_t       cfg,
	input  logic                 valid_s1,
	input  logic                 func_s1,
	input  sfas_pkg::pos_t       inc_s1,
	output sfas_pkg::stage_ctl_t ctl,
	sfas_out_if.source           results
);
	import sfas_pkg::*;

	pos_t       pos_q;
	logic       dir_q;
	logic       active_q;
	logic [7:0] wrap_q;

	result_t    res_s2;
	logic       res_v_s2;

	logic       take;
	logic       tick;
	logic       back_eff;
	pos_t       delta;
	pos_t       sum;
	frame_t     f;
	frame_t     s_fr;
	frame_t     e_fr;
	frame_t     freeze;
	frame_t     new_frame;
	logic       set_pos;
	logic       reached;
	logic       dir_n;
	logic       active_n;
	logic [7:0] wrap_inc;
	logic [7:0] wrap_n;
	pos_t       pos_n;

	assign take = valid_s1 && (!res_v_s2 || results.ready);
	assign ctl  = '{valid: valid_s1, take: take};

	always_comb begin
		tick     = (func_s1 == FUNC_TICK) && active_q;
		back_eff = (cfg.anim_mode == MODE_REVERSED) ? 1'b1 : dir_q;
		delta    = tick ? inc_s1 : '0;
		sum      = back_eff ? pos_q - delta : pos_q + delta;

		// Integer frame, truncated towards zero.
		f = {sum[POS_BITS-1], sum[POS_BITS-1:FRAC_BITS]}
			+ CALC_BITS'(sum[POS_BITS-1] && (|sum[FRAC_BITS-1:0]));

		s_fr = frame_t'({1'b0, cfg.start_frame});
		e_fr = s_fr + frame_t'({1'b0, cfg.frame_count}) - frame_t'(1);

		set_pos   = 1'b0;
		new_frame = f;
		reached   = 1'b0;
		freeze    = e_fr;
		dir_n     = dir_q;
		active_n  = active_q;
		wrap_inc  = (wrap_q == 8'hFF) ? wrap_q : wrap_q + 8'd1;
		wrap_n    = wrap_q;
		pos_n     = pos_q;

		if (func_s1 == FUNC_PLAY) begin
			set_pos   = 1'b1;
			new_frame = s_fr;
			dir_n     = 1'b0;
			active_n  = 1'b1;
		end else if (active_q) begin
			pos_n = sum;
			case (cfg.anim_mode)
				MODE_REVERSED: begin
					dir_n  = 1'b1;
					freeze = s_fr;
					if (f < s_fr) begin
						set_pos   = 1'b1;
						new_frame = e_fr;
						reached   = 1'b1;
					end
				end
				MODE_PING_PONG: begin
					if (!dir_q && (f > e_fr)) begin
						set_pos   = 1'b1;
						new_frame = e_fr;
						dir_n     = 1'b1;
						reached   = 1'b1;
					end else if (dir_q && (f < s_fr)) begin
						set_pos   = 1'b1;
						new_frame = s_fr;
						dir_n     = 1'b0;
						reached   = 1'b1;
					end
					freeze = dir_n ? s_fr : e_fr;
				end
				default: begin
					if (f > e_fr) begin
						set_pos   = 1'b1;
						new_frame = s_fr;
						reached   = 1'b1;
					end
				end
			endcase

			if (reached && (cfg.repeat_limit != 8'd0)) begin
				wrap_n = wrap_inc;
				if (wrap_inc >= cfg.repeat_limit) begin
					set_pos   = 1'b1;
					new_frame = freeze;
					active_n  = 1'b0;
				end
			end
		end

		if (set_pos) begin
			pos_n = {new_frame[FRAME_BITS-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			dir_q    <= 1'b0;
			active_q <= 1'b1;
			wrap_q   <= '0;
			res_v_s2 <= 1'b0;
		end else begin
			if (take) begin
				pos_q    <= pos_n;
				dir_q    <= dir_n;
				active_q <= active_n;
				wrap_q   <= wrap_n;
			end
			if (take) begin
				res_v_s2 <= 1'b1;
			end else if (results.ready) begin
				res_v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2.frame_index     <= new_frame[8:0];
			res_s2.active          <= active_n;
			res_s2.reached_end     <= reached;
			res_s2.moving_backward <= dir_n;
		end
	end

	assign results.valid           = res_v_s2;
	assign results.frame_index     = res_s2.frame_index;
	assign results.active          = res_s2.active;
	assign results.reached_end     = res_s2.reached_end;
	assign results.moving_backward = res_s2.moving_backward;

endmodule

[src/sfas_checker.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer port checker
// Watches the channel ports of the core and checks flow behaviour.
// ----------------------------------------------------------------------------
`include "sprite_frame_animation_sequencer_core_defines.svh"

module sfas_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [8:0] out_frame_index,
	input logic       out_active,
	input logic       out_reached_end,
	input logic       out_moving_backward
);

	`SFAS_ASSERT_NEXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SFAS_ASSERT_NEXT(a_res_stable, clk, arst_n, out_valid && !out_ready, $stable(out_frame_index) && $stable(out_active) && $stable(out_reached_end) && $stable(out_moving_backward))
	`SFAS_ASSERT_NEXT(a_word_flows, clk, arst_n, (in_valid && in_ready) ##1 out_ready, out_valid)
	`SFAS_ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind sprite_frame_animation_sequencer_core sfas_checker u_sfas_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (items.valid),
	.in_ready            (items.ready),
	.out_valid           (results.valid),
	.out_ready           (results.ready),
	.out_frame_index     (results.frame_index),
	.out_active          (results.active),
	.out_reached_end     (results.reached_end),
	.out_moving_backward (results.moving_backward)
);

[sim/sfas_frame_checker.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer: frame checker
// Watches the configuration port and both word channels, keeps its own copy
// of the animation state, predicts the result word of every accepted command
// word and compares it with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sfas_frame_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfas_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sfas_pkg::CFG_DATA_BITS-1:0] cfg_data,
	sfas_in_if                                 items,
	sfas_out_if                                results,
	output int                                 mismatches,
	output int                                 frames_owed
);
	import sfas_pkg::*;

	cfg_t    setup;
	pos_t    position;
	logic    backward;
	logic    playing;
	logic [7:0] wrap_count;
	result_t pending_frames[$];

	function automatic int whole_frame(input pos_t p);
		int v;
		v = $signed(p);
		if (v < 0)
			return -((-v) >> FRAC_BITS);
		return v >> FRAC_BITS;
	endfunction

	function automatic pos_t frame_to_pos(input int fr);
		return pos_t'(fr * (1 << FRAC_BITS));
	endfunction

	function automatic result_t advance_animation(input logic f, input logic [15:0] dt);
		int         first;
		int         last;
		int         fr;
		int         freeze;
		logic       hit;
		logic [63:0] wide;
		result_t    r;
		first = int'(setup.start_frame);
		last = first + int'(setup.frame_count) - 1;
		hit = 1'b0;
		freeze = 0;
		if (f == FUNC_PLAY) begin
			backward = 1'b0;
			playing = 1'b1;
			position = frame_to_pos(first);
		end else if (playing) begin
			wide = 64'(setup.frames_per_second) * 64'(dt);
			wide = (FRAC_BITS >= 16) ? wide << SHL : wide >> SHR;
			if (setup.anim_mode == MODE_REVERSED)
				backward = 1'b1;
			position = backward ? position - pos_t'(wide) : position + pos_t'(wide);
			fr = whole_frame(position);
			case (setup.anim_mode)
				MODE_REVERSED: begin
					if (fr < first) begin
						position = frame_to_pos(last);
						freeze = first;
						hit = 1'b1;
					end
				end
				MODE_PING_PONG: begin
					if (!backward && fr > last) begin
						position = frame_to_pos(last);
						backward = 1'b1;
						hit = 1'b1;
					end else if (backward && fr < first) begin
						position = frame_to_pos(first);
						backward = 1'b0;
						hit = 1'b1;
					end
					freeze = backward ? first : last;
				end
				default: begin
					if (fr > last) begin
						position = frame_to_pos(first);
						freeze = last;
						hit = 1'b1;
					end
				end
			endcase
			if (hit && setup.repeat_limit != 8'd0) begin
				if (wrap_count != 8'hFF)
					wrap_count++;
				if (wrap_count >= setup.repeat_limit) begin
					position = frame_to_pos(freeze);
					playing = 1'b0;
				end
			end
		end
		r.frame_index = 9'(whole_frame(position));
		r.active = playing;
		r.reached_end = hit;
		r.moving_backward = backward;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		result_t predicted;
		if (!arst_n) begin
			setup.frames_per_second = 8'd0;
			setup.start_frame = 8'd0;
			setup.frame_count = 9'd1;
			setup.anim_mode = MODE_NORMAL;
			setup.repeat_limit = 8'd0;
			position = '0;
			backward = 1'b0;
			playing = 1'b1;
			wrap_count = 8'd0;
			pending_frames.delete();
			mismatches = 0;
			frames_owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FPS:    setup.frames_per_second = cfg_data[7:0];
					REG_START:  setup.start_frame = cfg_data[7:0];
					REG_COUNT:  setup.frame_count = cfg_data[8:0];
					REG_MODE:   setup.anim_mode = cfg_data[1:0];
					REG_REPEAT: setup.repeat_limit = cfg_data[7:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				got.frame_index = results.frame_index;
				got.active = results.active;
				got.reached_end = results.reached_end;
				got.moving_backward = results.moving_backward;
				if (pending_frames.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word %0d/%0b/%0b/%0b",
						$time, got.frame_index, got.active, got.reached_end,
						got.moving_backward);
				end else begin
					want = pending_frames.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected %0d/%0b/%0b/%0b, actual %0d/%0b/%0b/%0b",
							$time, want.frame_index, want.active, want.reached_end,
							want.moving_backward, got.frame_index, got.active,
							got.reached_end, got.moving_backward);
					end
				end
			end
			if (items.valid && items.ready) begin
				predicted = advance_animation(items.func, items.delta_time);
				pending_frames.insert(pending_frames.size(), predicted);
			end
			frames_owed = pending_frames.size();
		end
	end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Sprite frame animation sequencer testbench
// Drives directed and random command words through normal, reversed,
// ping-pong and unused modes under a range of register settings, with random
// gaps on the command side and random stalls on the result side. A separate
// frame checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
	import sfas_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES = 28;
	localparam logic [CFG_IDX_BITS-1:0] SETUP_ORDER [5] =
		'{REG_FPS, REG_START, REG_COUNT, REG_MODE, REG_REPEAT};

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int                       mismatches;
	int                       frames_owed;
	int                       idle_cycles = 0;
	bit                       calm = 1'b1;

	sfas_in_if  items_if ();
	sfas_out_if results_if ();

	sprite_frame_animation_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_if),
		.results   (results_if)
	);

	sfas_frame_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.items       (items_if),
		.results     (results_if),
		.mismatches  (mismatches),
		.frames_owed (frames_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_delta();
		case ($urandom_range(0, 19))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4, 5, 6: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 16'h1000));
		endcase
	endfunction

	initial begin
		int   hold;
		logic level;
		hold = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm)
				results_if.ready = 1'b1;
			else if (hold > 0)
				hold--;
			else begin
				level = $urandom_range(0, 9) < 7;
				hold = level ? $urandom_range(0, 7) : pick_gap();
				results_if.ready = level;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (items_if.valid && items_if.ready) ||
				(results_if.valid && results_if.ready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic issue_word(input logic f, input logic [15:0] dt);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			items_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_if.func = f;
		items_if.delta_time = dt;
		items_if.valid = 1'b1;
		do @(posedge clk); while (!items_if.ready);
		@(negedge clk);
	endtask

	task automatic apply_setup(input int fps, input int first, input int count,
			input logic [1:0] mode, input int limit);
		logic [CFG_DATA_BITS-1:0] value [5];
		value = '{CFG_DATA_BITS'(fps), CFG_DATA_BITS'(first), CFG_DATA_BITS'(count),
			CFG_DATA_BITS'(mode), CFG_DATA_BITS'(limit)};
		items_if.valid = 1'b0;
		wait (frames_owed == 0);
		repeat (4) @(negedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we = 1'b1;
			cfg_index = SETUP_ORDER[i];
			cfg_data = value[i];
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	initial begin
		int         fps;
		int         first;
		int         count;
		int         limit;
		logic [1:0] mode;
		int         words;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FPS;
		cfg_data = '0;
		items_if.valid = 1'b0;
		items_if.func = FUNC_TICK;
		items_if.delta_time = 16'h0000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full range normal mode, wrapping past the last frame.
		apply_setup(255, 0, 256, MODE_NORMAL, 0);
		issue_word(FUNC_PLAY, 16'hFFFF);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_TICK, 16'h0000);
		issue_word(FUNC_TICK, 16'hFFFF);

		// Ping-pong bouncing at both ends until the repeat limit freezes it.
		apply_setup(255, 10, 5, MODE_PING_PONG, 2);
		issue_word(FUNC_PLAY, 16'h0000);
		issue_word(FUNC_TICK, 16'h0400);
		issue_word(FUNC_TICK, 16'h0800);
		issue_word(FUNC_TICK, 16'h1000);
		issue_word(FUNC_TICK, 16'hFFFF);

		// Reversed mode from the highest start frame.
		apply_setup(255, 255, 256, MODE_REVERSED, 0);
		issue_word(FUNC_PLAY, 16'h5A5A);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_TICK, 16'h0001);

		// Unused mode with an empty frame range; the count already reached the
		// limit, so the wrap after a restart freezes at once.
		apply_setup(1, 0, 0, 2'd3, 3);
		issue_word(FUNC_PLAY, 16'h0000);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_PLAY, 16'hA5A5);
		issue_word(FUNC_TICK, 16'h0000);

		// Turn backward in ping-pong, then keep falling in normal mode.
		apply_setup(255, 0, 256, MODE_PING_PONG, 0);
		issue_word(FUNC_PLAY, 16'h0000);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_TICK, 16'hFFFF);
		apply_setup(255, 0, 256, MODE_NORMAL, 0);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_TICK, 16'hFFFF);
		issue_word(FUNC_TICK, 16'hFFFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: fps = 0;
				1: fps = 255;
				2: fps = 1;
				default: fps = $urandom_range(1, 255);
			endcase
			case ($urandom_range(0, 5))
				0: first = 0;
				1: first = 255;
				default: first = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 9))
				0: count = 0;
				1: count = 256;
				2: count = 1;
				3: count = $urandom_range(1, 256);
				default: count = $urandom_range(2, 12);
			endcase
			if ($urandom_range(0, 9) == 0)
				mode = 2'd3;
			else
				mode = 2'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
				5, 6, 7: limit = $urandom_range(1, 6);
				8: limit = 255;
				9: limit = $urandom_range(1, 255);
				default: limit = 0;
			endcase
			apply_setup(fps, first, count, mode, limit);
			words = $urandom_range(40, 62);
			issue_word(FUNC_PLAY, 16'($urandom_range(0, 65535)));
			for (int n = 1; n < words; n++) begin
				if ($urandom_range(0, 99) < 6)
					issue_word(FUNC_PLAY, 16'($urandom_range(0, 65535)));
				else
					issue_word(FUNC_TICK, pick_delta());
			end
		end

		items_if.valid = 1'b0;
		wait (frames_owed == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
